### hdl/vcg_pkg.sv
// Shared types, cube topology tables and helpers for the voxel cell edge grouping block.
package vcg_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int CORNERS         = 8;
	localparam int EDGES           = 12;
	localparam int FACES           = 6;
	localparam int FACE_SIDES      = 4;
	localparam int LABEL_BITS      = 3;
	localparam int COUNT_BITS      = 3;
	localparam int LABELS_W        = EDGES * LABEL_BITS;

	typedef logic [2:0]             corner_idx_t;
	typedef logic [3:0]             edge_idx_t;
	typedef logic [2:0]             face_idx_t;
	typedef logic [CORNERS-1:0]     mask_t;
	typedef logic [EDGES-1:0]       row_t;
	typedef row_t [EDGES-1:0]       mat_t;
	typedef logic [LABEL_BITS-1:0]  label_t;
	typedef logic [COUNT_BITS-1:0]  count_t;
	typedef logic [LABELS_W-1:0]    labels_t;

	typedef struct packed {
		logic      valid;
		edge_idx_t a;
		edge_idx_t b;
	} join_t;

	typedef struct packed {
		join_t [1:0] pair;
	} face_join_t;

	localparam corner_idx_t EDGE_END_A [EDGES] = '{
		3'd0, 3'd1, 3'd3, 3'd0, 3'd4, 3'd5, 3'd7, 3'd4, 3'd0, 3'd1, 3'd2, 3'd3
	};
	localparam corner_idx_t EDGE_END_B [EDGES] = '{
		3'd1, 3'd2, 3'd2, 3'd3, 3'd5, 3'd6, 3'd6, 3'd7, 3'd4, 3'd5, 3'd6, 3'd7
	};

	localparam edge_idx_t FACE_EDGE [FACES][FACE_SIDES] = '{
		'{4'd0, 4'd9,  4'd4, 4'd8},
		'{4'd1, 4'd10, 4'd5, 4'd9},
		'{4'd2, 4'd10, 4'd6, 4'd11},
		'{4'd3, 4'd11, 4'd7, 4'd8},
		'{4'd0, 4'd1,  4'd2, 4'd3},
		'{4'd4, 4'd5,  4'd6, 4'd7}
	};

	localparam corner_idx_t FACE_LEAD [FACES] = '{
		3'd0, 3'd1, 3'd3, 3'd0, 3'd0, 3'd4
	};

	function automatic row_t edge_cross(input mask_t mask);
		row_t c;
		for (int e = 0; e < EDGES; e++) begin
			c[e] = mask[EDGE_END_A[e]] ^ mask[EDGE_END_B[e]];
		end
		return c;
	endfunction

endpackage

### hdl/vcg_if.sv
// Stream interfaces for corner-sample items and edge-group result items.
interface vcg_in_if #(
	parameter int SAMPLE_BITS = vcg_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] corner_0;
	logic signed [SAMPLE_BITS-1:0] corner_1;
	logic signed [SAMPLE_BITS-1:0] corner_2;
	logic signed [SAMPLE_BITS-1:0] corner_3;
	logic signed [SAMPLE_BITS-1:0] corner_4;
	logic signed [SAMPLE_BITS-1:0] corner_5;
	logic signed [SAMPLE_BITS-1:0] corner_6;
	logic signed [SAMPLE_BITS-1:0] corner_7;

	modport source (
		output valid, corner_0, corner_1, corner_2, corner_3,
		       corner_4, corner_5, corner_6, corner_7,
		input  ready
	);
	modport sink (
		input  valid, corner_0, corner_1, corner_2, corner_3,
		       corner_4, corner_5, corner_6, corner_7,
		output ready
	);
endinterface

interface vcg_out_if;
	logic                   valid;
	logic                   ready;
	vcg_pkg::mask_t         sign_mask;
	vcg_pkg::count_t        group_count;
	vcg_pkg::labels_t       edge_group_labels;

	modport source (
		output valid, sign_mask, group_count, edge_group_labels,
		input  ready
	);
	modport sink (
		input  valid, sign_mask, group_count, edge_group_labels,
		output ready
	);
endinterface

### hdl/vcg_face_lane.sv
// One face lane: finds the crossing edges of a face and the pairs they join into.
module vcg_face_lane #(
	parameter vcg_pkg::face_idx_t FACE = '0
) (
	input  vcg_pkg::mask_t      mask,
	output vcg_pkg::face_join_t joins
);
	import vcg_pkg::*;

	row_t                   crossing;
	logic [FACE_SIDES-1:0]  c;
	logic [1:0]             first;
	logic [1:0]             last;
	logic [2:0]             n;
	edge_idx_t              e [FACE_SIDES];

	always_comb begin
		crossing = edge_cross(mask);
		for (int k = 0; k < FACE_SIDES; k++) begin
			e[k] = FACE_EDGE[FACE][k];
			c[k] = crossing[FACE_EDGE[FACE][k]];
		end
		n = 3'(c[0]) + 3'(c[1]) + 3'(c[2]) + 3'(c[3]);
		first = '0;
		last  = '0;
		for (int k = FACE_SIDES - 1; k >= 0; k--) begin
			if (c[k]) first = 2'(k);
		end
		for (int k = 0; k < FACE_SIDES; k++) begin
			if (c[k]) last = 2'(k);
		end

		joins = '0;
		if (n == 3'd2) begin
			joins.pair[0] = '{valid: 1'b1, a: e[first], b: e[last]};
		end else if (n == 3'd4) begin
			if (mask[FACE_LEAD[FACE]]) begin
				joins.pair[0] = '{valid: 1'b1, a: e[0], b: e[1]};
				joins.pair[1] = '{valid: 1'b1, a: e[2], b: e[3]};
			end else begin
				joins.pair[0] = '{valid: 1'b1, a: e[3], b: e[0]};
				joins.pair[1] = '{valid: 1'b1, a: e[1], b: e[2]};
			end
		end
	end
endmodule

### hdl/vcg_merge.sv
// Merge stage: combines face-lane joins, closes connectivity and numbers the groups.
module vcg_merge (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  vcg_pkg::mask_t       mask,
	input  vcg_pkg::face_join_t  joins [vcg_pkg::FACES],
	output logic                 out_valid,
	input  logic                 out_ready,
	output vcg_pkg::mask_t       sign_mask,
	output vcg_pkg::count_t      group_count,
	output vcg_pkg::labels_t     edge_group_labels
);
	import vcg_pkg::*;

	function automatic mat_t mat_square(input mat_t m);
		mat_t r;
		for (int i = 0; i < EDGES; i++) begin
			for (int j = 0; j < EDGES; j++) begin
				r[i][j] = |(m[i] & m[j]);
			end
		end
		return r;
	endfunction

	logic  v_s2, v_s3, v_s4, v_s5, v_s6;
	logic  rdy_s2, rdy_s3, rdy_s4, rdy_s5, rdy_s6;
	mat_t  r_s2, r_s3, r_s4, r_s5;
	row_t  cross_s2, cross_s3, cross_s4, cross_s5;
	mask_t mask_s2, mask_s3, mask_s4, mask_s5, mask_s6;
	count_t  count_s6;
	labels_t labels_s6;

	mat_t    adj;
	row_t    leader;
	row_t    upto;
	row_t    ld;
	logic    acc;
	count_t  cnt;
	count_t  total;
	labels_t lab;

	assign rdy_s6   = !v_s6 || out_ready;
	assign rdy_s5   = !v_s5 || rdy_s6;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	always_comb begin
		adj = '0;
		for (int i = 0; i < EDGES; i++) begin
			adj[i][i] = 1'b1;
		end
		for (int f = 0; f < FACES; f++) begin
			for (int p = 0; p < 2; p++) begin
				if (joins[f].pair[p].valid) begin
					adj[joins[f].pair[p].a][joins[f].pair[p].b] = 1'b1;
					adj[joins[f].pair[p].b][joins[f].pair[p].a] = 1'b1;
				end
			end
		end
	end

	always_comb begin
		for (int j = 0; j < EDGES; j++) begin
			leader[j] = cross_s5[j] &&
				!(|(r_s5[j] & row_t'((row_t'(1) << j) - row_t'(1))));
		end
		total = '0;
		for (int j = 0; j < EDGES; j++) begin
			total = total + count_t'(leader[j]);
		end
		lab = '0;
		for (int i = 0; i < EDGES; i++) begin
			ld  = r_s5[i] & leader;
			acc = 1'b0;
			for (int j = EDGES - 1; j >= 0; j--) begin
				acc     = acc | ld[j];
				upto[j] = acc;
			end
			cnt = '0;
			for (int j = 0; j < EDGES; j++) begin
				cnt = cnt + count_t'(leader[j] & upto[j]);
			end
			if (cross_s5[i]) begin
				lab[i*LABEL_BITS +: LABEL_BITS] = label_t'(cnt);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy_s2) v_s2 <= in_valid;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
			if (rdy_s6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			r_s2     <= adj;
			cross_s2 <= edge_cross(mask);
			mask_s2  <= mask;
		end
		if (rdy_s3 && v_s2) begin
			r_s3     <= mat_square(r_s2);
			cross_s3 <= cross_s2;
			mask_s3  <= mask_s2;
		end
		if (rdy_s4 && v_s3) begin
			r_s4     <= mat_square(r_s3);
			cross_s4 <= cross_s3;
			mask_s4  <= mask_s3;
		end
		if (rdy_s5 && v_s4) begin
			r_s5     <= mat_square(r_s4);
			cross_s5 <= cross_s4;
			mask_s5  <= mask_s4;
		end
		if (rdy_s6 && v_s5) begin
			count_s6  <= total;
			labels_s6 <= lab;
			mask_s6   <= mask_s5;
		end
	end

	assign out_valid         = v_s6;
	assign sign_mask         = mask_s6;
	assign group_count       = count_s6;
	assign edge_group_labels = labels_s6;
endmodule

### hdl/voxel_cell_edge_grouping.sv
// Top level: corner compare lanes, face lanes and the group merge pipeline.
// Throughput: one item per cycle unless result.ready is low; six pipeline stages,
// three squaring the 12x12 edge reachability matrix, each stalling only when full.
// Reset: arst_n clears all stage valid flags and sets threshold_q to 0.
module voxel_cell_edge_grouping #(
	parameter int SAMPLE_BITS = vcg_pkg::SAMPLE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [SAMPLE_BITS-1:0] cfg_wdata,
	vcg_in_if.sink                 samples,
	vcg_out_if.source              result
);
	import vcg_pkg::*;

	logic signed [SAMPLE_BITS-1:0] threshold_q;
	logic signed [SAMPLE_BITS-1:0] corner [CORNERS];
	mask_t       mask_d;
	mask_t       mask_s1;
	logic        v_s1;
	logic        rdy_s1;
	logic        merge_ready;
	face_join_t  joins [FACES];

	assign corner[0] = samples.corner_0;
	assign corner[1] = samples.corner_1;
	assign corner[2] = samples.corner_2;
	assign corner[3] = samples.corner_3;
	assign corner[4] = samples.corner_4;
	assign corner[5] = samples.corner_5;
	assign corner[6] = samples.corner_6;
	assign corner[7] = samples.corner_7;

	always_comb begin
		for (int i = 0; i < CORNERS; i++) begin
			mask_d[i] = corner[i] < threshold_q;
		end
	end

	assign rdy_s1        = !v_s1 || merge_ready;
	assign samples.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			v_s1        <= 1'b0;
		end else begin
			if (cfg_we) threshold_q <= cfg_wdata;
			if (rdy_s1) v_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && samples.valid) mask_s1 <= mask_d;
	end

	for (genvar f = 0; f < FACES; f++) begin : g_face
		vcg_face_lane #(
			.FACE (face_idx_t'(f))
		) u_face (
			.mask  (mask_s1),
			.joins (joins[f])
		);
	end

	vcg_merge u_merge (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (v_s1),
		.in_ready          (merge_ready),
		.mask              (mask_s1),
		.joins             (joins),
		.out_valid         (result.valid),
		.out_ready         (result.ready),
		.sign_mask         (result.sign_mask),
		.group_count       (result.group_count),
		.edge_group_labels (result.edge_group_labels)
	);
endmodule

### hdl/vcg_checker.sv
// Port-level checker for the voxel cell edge grouping block, with its bind.
module vcg_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_ready,
	input vcg_pkg::mask_t         sign_mask,
	input vcg_pkg::count_t        group_count,
	input vcg_pkg::labels_t       edge_group_labels
);
	import vcg_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> group_count <= count_t'(4))
		else $error("group count above four");

	a_uniform: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((group_count == '0) ==
			(sign_mask == 8'h00 || sign_mask == 8'hFF)))
		else $error("group count disagrees with uniformity of mask");

	a_labels_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((group_count == '0) == (edge_group_labels == '0)))
		else $error("labels disagree with group count");
endmodule

bind voxel_cell_edge_grouping vcg_checker u_vcg_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.out_valid         (result.valid),
	.out_ready         (result.ready),
	.sign_mask         (result.sign_mask),
	.group_count       (result.group_count),
	.edge_group_labels (result.edge_group_labels)
);
